// ===== design/lru_kv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lru_kv_pkg;

  // storage geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // field widths
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // operation carried on the input tuser
  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_e;

endpackage

`default_nettype wire

// ===== design/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
//
// Input channel s_axis: tuser[0] selects get (0) or put (1), tdata carries
// the key (bits 31:0) and the value to store on a put (bits 63:32).
// Output channel m_axis: one item per input item. tdata holds the value read
// (stored value on a get hit, all ones on a get miss, zero on a put) in bits
// 31:0 and the evicted key in bits 63:32; tuser[0] flags that the key was
// present, tuser[1] that a put evicted the least recent entry.
// Config channel cfg: writes the capacity (0 acts as 1, above 16 as 16).
//
// Each accepted item moves from the input register to the output register.
// One item is accepted every cycle unless stalled: the input register feeds
// a single pass of parallel key compares and rank updates over all 16
// entries, which writes entry state and output register at the same edge.
// Reset empties the cache and sets the capacity to 16; no clearing pass.
// While the receiver stalls, the output register holds its item and the
// input register takes one more item, then tready drops until the output
// drains.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lru_kv_pkg::CAP_W-1:0]       cfg_data_i,
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lru_kv_pkg::KEY_W+lru_kv_pkg::DATA_W-1:0] s_axis_tdata,  // key, value
  input  logic [0:0]                         s_axis_tuser,                // func
  // result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lru_kv_pkg::DATA_W+lru_kv_pkg::KEY_W-1:0] m_axis_tdata,  // read_value, evicted_key
  output logic [1:0]                         m_axis_tuser                 // found, evicted
);

  import lru_kv_pkg::*;

  // control and status registers
  logic [CAP_W-1:0]  cap_q;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]  age_q [ENTRIES];
  logic [IDX_W-1:0]  age_d [ENTRIES];
  logic [CNT_W-1:0]  occ_q, occ_d;

  // entry payload, undefined until written
  logic [KEY_W-1:0]  key_q [ENTRIES];
  logic [DATA_W-1:0] val_q [ENTRIES];

  // input register
  logic              in_valid_q;
  func_e             in_func_q;
  logic [KEY_W-1:0]  in_key_q;
  logic [DATA_W-1:0] in_val_q;

  // output register
  logic              out_valid_q;
  logic              out_found_q, out_found_d;
  logic              out_ev_q, out_ev_d;
  logic [DATA_W-1:0] out_rd_q, out_rd_d;
  logic [KEY_W-1:0]  out_evk_q, out_evk_d;

  // single pass signals
  logic              adv;
  logic              fire;
  logic [ENTRIES-1:0] hit_vec, lru_vec;
  logic              hit_any, free_any, need_evict, do_insert;
  logic [IDX_W-1:0]  hit_idx, lru_idx, free_idx, slot_idx, wr_idx;
  logic [IDX_W-1:0]  hit_age, lru_age;
  logic [DATA_W-1:0] hit_val;
  logic [KEY_W-1:0]  lru_key;
  logic [CNT_W-1:0]  eff_cap;
  logic              wr_key_en, wr_val_en;

  // handshakes
  assign cfg_ready_o   = 1'b1;
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;
  assign fire          = in_valid_q && adv;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_evk_q, out_rd_q};
  assign m_axis_tuser  = {out_ev_q, out_found_q};

  // effective capacity clamp
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if ({1'b0, cap_q} > (CAP_W+1)'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  // parallel lookup over all entries
  assign lru_age = IDX_W'(occ_q - CNT_W'(1));

  always_comb begin
    hit_val  = '0;
    hit_age  = '0;
    lru_key  = '0;
    hit_idx  = '0;
    lru_idx  = '0;
    free_idx = '0;
    free_any = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == in_key_q);
      lru_vec[i] = valid_q[i] && (occ_q != '0) && (age_q[i] == lru_age);
      hit_val    = hit_val | (hit_vec[i] ? val_q[i] : '0);
      hit_age    = hit_age | (hit_vec[i] ? age_q[i] : '0);
      lru_key    = lru_key | (lru_vec[i] ? key_q[i] : '0);
      hit_idx    = hit_idx | (hit_vec[i] ? IDX_W'(i) : '0);
      lru_idx    = lru_idx | (lru_vec[i] ? IDX_W'(i) : '0);
    end
    // lowest free slot
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
    hit_any = |hit_vec;
  end

  // next state and result
  always_comb begin
    valid_d     = valid_q;
    age_d       = age_q;
    occ_d       = occ_q;
    out_found_d = 1'b0;
    out_rd_d    = '0;
    out_ev_d    = 1'b0;
    out_evk_d   = '0;
    wr_key_en   = 1'b0;
    wr_val_en   = 1'b0;
    wr_idx      = free_idx;
    need_evict  = ({1'b0, occ_q} + (CNT_W+1)'(1) > {1'b0, eff_cap}) && (occ_q != '0);
    do_insert   = free_any || need_evict;
    slot_idx    = free_any ? free_idx : lru_idx;

    if (fire) begin
      if (hit_any) begin
        // hit: read or overwrite, then promote
        out_found_d = 1'b1;
        if (in_func_q == FUNC_GET) begin
          out_rd_d = hit_val;
        end else begin
          wr_val_en = 1'b1;
          wr_idx    = hit_idx;
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && age_q[i] < hit_age) begin
            age_d[i] = age_q[i] + IDX_W'(1);
          end
        end
        age_d[hit_idx] = '0;
      end else if (in_func_q == FUNC_GET) begin
        out_rd_d = '1;
      end else begin
        // miss on put: evict if over capacity, then insert as most recent
        if (need_evict) begin
          out_ev_d         = 1'b1;
          out_evk_d        = lru_key;
          valid_d[lru_idx] = 1'b0;
          occ_d            = occ_q - CNT_W'(1);
        end
        if (do_insert) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_d[i]) begin
              age_d[i] = age_q[i] + IDX_W'(1);
            end
          end
          valid_d[slot_idx] = 1'b1;
          age_d[slot_idx]   = '0;
          occ_d             = occ_d + CNT_W'(1);
          wr_key_en         = 1'b1;
          wr_val_en         = 1'b1;
          wr_idx            = slot_idx;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      valid_q     <= '0;
      occ_q       <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      valid_q <= valid_d;
      occ_q   <= occ_d;
      age_q   <= age_d;
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (wr_key_en) begin
      key_q[wr_idx] <= in_key_q;
    end
    if (wr_val_en) begin
      val_q[wr_idx] <= in_val_q;
    end
  end

  // input and output payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func_q <= func_e'(s_axis_tuser[0]);
      in_key_q  <= s_axis_tdata[KEY_W-1:0];
      in_val_q  <= s_axis_tdata[KEY_W+DATA_W-1:KEY_W];
    end
    if (fire) begin
      out_found_q <= out_found_d;
      out_rd_q    <= out_rd_d;
      out_ev_q    <= out_ev_d;
      out_evk_q   <= out_evk_d;
    end
  end

  // occupancy tracks the number of valid entries
  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy does not match valid entries");

  // occupancy never exceeds the store
  a_occ_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(ENTRIES))
    else $error("occupancy above entry count");

  // eviction only on a miss
  a_ev_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_found_q && out_ev_q))
    else $error("eviction reported on a hit");

  // a get never changes occupancy
  a_get_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_func_q == FUNC_GET) |=> $stable(occ_q))
    else $error("get changed occupancy");

endmodule

`default_nettype wire
